// ----- src/kf_pkg.sv -----
// Shared types and constants for the 5x5 Kuwahara RGB filter.
`default_nettype none
package kf_pkg;
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int LINES_KEPT   = 4;
  localparam int SLOT_W       = $clog2(LINES_KEPT);
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WREG_W       = 11;
  localparam int HREG_W       = 13;
  localparam int ROW_W        = 13;
  localparam int OROW_W       = 12;
  localparam int LAG_W        = 12;
  localparam int PIX_W        = 24;
  localparam int CH_W         = 8;
  localparam int SUM_W        = 12;
  localparam int SQ_W         = 17;
  localparam int SSUM_W       = 21;
  localparam int SCORE_W      = 18;
  localparam int RECIP9       = 7282;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef pix_t [8:0]         quad_pix_t;
  typedef logic [CH_W-1:0]    chan_t;
  typedef chan_t [2:0]        rgb_t;
  typedef logic [SCORE_W-1:0] score_t;

  typedef struct packed {
    score_t score;
    rgb_t   mean;
  } lane_res_t;
endpackage
`default_nettype wire

// ----- src/kf_ram.sv -----
// Generic single-write, single-read RAM with registered read-first output.
`default_nettype none
module kf_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- src/kf_lane.sv -----
// One quadrant lane: 3x3 means and summed channel variance, four register stages.
`default_nettype none
module kf_lane (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire kf_pkg::quad_pix_t pix_i,
  output kf_pkg::lane_res_t      res_o
);
  import kf_pkg::*;

  logic [2:0][SUM_W-1:0]   sum_r;
  quad_pix_t               val1_r;
  rgb_t                    mean2_r;
  quad_pix_t               val2_r;
  logic [2:0][8:0][SQ_W-1:0] sq_r;
  rgb_t                    mean3_r;
  score_t                  score_r;
  rgb_t                    mean4_r;

  logic [2:0][SUM_W-1:0]   sum_nxt;
  rgb_t                    mean_nxt;
  logic [2:0][8:0][SQ_W-1:0] sq_nxt;
  score_t                  score_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = '0;
      for (int k = 0; k < 9; k++) begin
        sum_nxt[c] = sum_nxt[c] + SUM_W'(pix_i[k][c*CH_W +: CH_W]);
      end
    end
  end

  // Divide by nine through a scaled reciprocal; exact over the 0..2295 range.
  always_comb begin
    logic [SUM_W+12:0] prod;
    for (int c = 0; c < 3; c++) begin
      prod        = (SUM_W+13)'(sum_r[c]) * (SUM_W+13)'(RECIP9);
      mean_nxt[c] = prod[16 +: CH_W];
    end
  end

  always_comb begin
    logic signed [CH_W:0]     df;
    logic signed [2*CH_W+1:0] p;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 9; k++) begin
        df           = $signed({1'b0, val2_r[k][c*CH_W +: CH_W]}) - $signed({1'b0, mean2_r[c]});
        p            = df * df;
        sq_nxt[c][k] = p[SQ_W-1:0];
      end
    end
  end

  always_comb begin
    logic [SSUM_W-1:0] ss;
    score_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      ss = '0;
      for (int k = 0; k < 9; k++) begin
        ss = ss + SSUM_W'(sq_r[c][k]);
      end
      score_nxt = score_nxt + SCORE_W'(ss >> 3);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum_nxt;
      val1_r  <= pix_i;
      mean2_r <= mean_nxt;
      val2_r  <= val1_r;
      sq_r    <= sq_nxt;
      mean3_r <= mean2_r;
      score_r <= score_nxt;
      mean4_r <= mean3_r;
    end
  end

  assign res_o.score = score_r;
  assign res_o.mean  = mean4_r;
endmodule
`default_nettype wire

// ----- src/kf_merge.sv -----
// Picks the lane with the smallest variance score and registers its means.
`default_nettype none
module kf_merge (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire kf_pkg::lane_res_t res_i [4],
  output kf_pkg::rgb_t           rgb_o
);
  import kf_pkg::*;

  rgb_t       rgb_r;
  logic [1:0] best;

  // Strict compare keeps the lower quadrant on a tie.
  always_comb begin
    best = 2'd0;
    for (int q = 1; q < 4; q++) begin
      if (res_i[q].score < res_i[best].score) begin
        best = 2'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb_r <= res_i[best].mean;
    end
  end

  assign rgb_o = rgb_r;
endmodule
`default_nettype wire

// ----- src/kuwahara5x5_rgb_filter_top.sv -----
// Streaming 5x5 Kuwahara filter for RGB pixels in raster order.
// Throughput: one request per clock; the whole pipeline stalls only while the output is held.
// A result passes stage 1, the window, the lane stages and the merge register after the request
// completing its window; it trails its pixel by 2*W+2 requests, flushed by later requests.
// Reset (synchronous, active low) clears counters, window and valid bits and loads 640x480;
// line stores are not cleared, as reads only reach rows written in the current frame.
`default_nettype none
module kuwahara5x5_rgb_filter_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [23:0]                 in_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  wire logic                        in_tuser,   // drain
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [23:0]                 out_tdata,  // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic                             out_tlast,
  input  wire logic                        cfg_we,
  input  wire kf_pkg::cfg_reg_t            cfg_addr,
  input  wire logic [kf_pkg::HREG_W-1:0]   cfg_wdata
);
  import kf_pkg::*;

  logic [WREG_W-1:0] fw_r;
  logic [HREG_W-1:0] fh_r;
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic [ROW_W-1:0]  in_row_r;
  logic [OROW_W-1:0] out_row_r;
  logic [LAG_W-1:0]  pre_r;

  logic [WREG_W-1:0] w_use;
  logic [HREG_W-1:0] h_use;
  logic [LAG_W-1:0]  lag;
  logic              en, acc, in_active, emit, last, col_wrap;
  logic [3:0]        rmask;
  logic [4:0]        cmask;
  pix_t              pix_in;

  always_comb begin
    if (fw_r == '0) begin
      w_use = WREG_W'(1);
    end else if (fw_r > WREG_W'(MAX_WIDTH)) begin
      w_use = WREG_W'(MAX_WIDTH);
    end else begin
      w_use = fw_r;
    end
    if (fh_r == '0) begin
      h_use = HREG_W'(1);
    end else if (fh_r > HREG_W'(HEIGHT_LIMIT)) begin
      h_use = HREG_W'(HEIGHT_LIMIT);
    end else begin
      h_use = fh_r;
    end
  end

  assign lag       = LAG_W'({w_use, 1'b0}) + LAG_W'(2);
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;
  assign in_active = in_row_r < h_use;
  assign pix_in    = (in_active && !in_tuser) ? in_tdata : '0;
  assign emit      = pre_r == lag;
  assign last      = ({1'b0, out_row_r} == h_use - HREG_W'(1))
                  && ({1'b0, out_col_r} == w_use - WREG_W'(1));
  assign col_wrap  = ({1'b0, in_col_r} + WREG_W'(1)) >= w_use;

  // Row r-k of the line store is live only if it lies inside the current frame.
  always_comb begin
    for (int k = 1; k <= 4; k++) begin
      rmask[k-1] = (in_row_r >= ROW_W'(k))
                && ({1'b0, in_row_r} < ({1'b0, h_use} + (ROW_W+1)'(k)));
    end
  end

  assign cmask[0] = out_col_r >= COL_W'(2);
  assign cmask[1] = out_col_r >= COL_W'(1);
  assign cmask[2] = 1'b1;
  assign cmask[3] = ({1'b0, out_col_r} + WREG_W'(1)) < w_use;
  assign cmask[4] = ({1'b0, out_col_r} + WREG_W'(2)) < w_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= WREG_W'(RESET_WIDTH);
      fh_r      <= HREG_W'(RESET_HEIGHT);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pre_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata[WREG_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        default:          fw_r <= fw_r;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pre_r     <= '0;
    end else if (acc) begin
      if (emit && last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        pre_r     <= '0;
      end else begin
        if (col_wrap) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + ROW_W'(1);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
        if (!emit) begin
          pre_r <= pre_r + LAG_W'(1);
        end else if (({1'b0, out_col_r} + WREG_W'(1)) >= w_use) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + OROW_W'(1);
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
    end
  end

  // Line stores: one RAM per row slot, read-first so the row four above is seen before overwrite.
  pix_t rd [LINES_KEPT];

  for (genvar i = 0; i < LINES_KEPT; i++) begin : g_line
    kf_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (acc && in_active && (in_row_r[SLOT_W-1:0] == SLOT_W'(i))),
      .waddr (in_col_r),
      .wdata (pix_in),
      .re    (acc),
      .raddr (in_col_r),
      .rdata (rd[i])
    );
  end

  logic              s1_v_r, s1_emit_r, s1_last_r;
  pix_t              s1_pix_r;
  logic [3:0]        s1_rmask_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [4:0]        s1_cmask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r   <= pix_in;
      s1_rmask_r <= rmask;
      s1_slot_r  <= in_row_r[SLOT_W-1:0];
      s1_cmask_r <= cmask;
      s1_emit_r  <= emit;
      s1_last_r  <= emit && last;
    end
  end

  pix_t col [5];
  pix_t win_r [5][5];

  always_comb begin
    logic [SLOT_W-1:0] sl;
    for (int j = 0; j < 4; j++) begin
      sl     = s1_slot_r + SLOT_W'(j);
      col[j] = s1_rmask_r[3-j] ? rd[sl] : '0;
    end
    col[4] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 5; s++) begin
        for (int i = 0; i < 5; i++) begin
          win_r[s][i] <= '0;
        end
      end
    end else if (en && s1_v_r) begin
      for (int s = 0; s < 4; s++) begin
        win_r[s] <= win_r[s+1];
      end
      for (int i = 0; i < 5; i++) begin
        win_r[4][i] <= col[i];
      end
    end
  end

  logic       s2_v_r, s2_last_r;
  logic [4:0] s2_cmask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmask_r <= s1_cmask_r;
      s2_last_r  <= s1_last_r;
    end
  end

  quad_pix_t quad [4];
  lane_res_t res  [4];

  always_comb begin
    int r0, c0;
    for (int q = 0; q < 4; q++) begin
      r0 = (q >> 1) * 2;
      c0 = (q & 1) * 2;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          quad[q][a*3+b] = s2_cmask_r[c0+b] ? win_r[c0+b][r0+a] : '0;
        end
      end
    end
  end

  for (genvar q = 0; q < 4; q++) begin : g_lane
    kf_lane u_lane (
      .clk   (clk),
      .en    (en),
      .pix_i (quad[q]),
      .res_o (res[q])
    );
  end

  rgb_t rgb;

  kf_merge u_merge (
    .clk   (clk),
    .en    (en),
    .res_i (res),
    .rgb_o (rgb)
  );

  logic [3:0] lv_r, ll_r;
  logic       out_v_r, out_l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      lv_r    <= {lv_r[2:0], s2_v_r};
      out_v_r <= lv_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r    <= {ll_r[2:0], s2_last_r};
      out_l_r <= ll_r[3];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_l_r;
  assign out_tdata  = rgb;
endmodule
`default_nettype wire

// ----- dv/tb_kuwahara5x5_rgb_filter_top.sv -----
// Self-checking testbench for the streaming 5x5 Kuwahara RGB filter top level.
module tb_kuwahara5x5_rgb_filter_top;
  import kf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_BUDGET  = 420;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } kpix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_addr = REG_FRAME_WIDTH;
  logic [HREG_W-1:0] cfg_wdata = '0;

  kuwahara5x5_rgb_filter_top dut (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic [23:0] lstore [LINES_KEPT*MAX_WIDTH];
  logic [23:0] win [5][5];
  int unsigned pcol, prow, ocol, orow;
  int unsigned fwidth = RESET_WIDTH, fheight = RESET_HEIGHT;
  kpix_t       filtered_q[$];
  int          errors = 0;
  int          sent = 0, got = 0, frames = 0;
  bit          no_idle = 1'b0;
  int          quiet = 0;

  function automatic int unsigned eff_width();
    if (fwidth == 0) return 1;
    if (fwidth > MAX_WIDTH) return MAX_WIDTH;
    return fwidth;
  endfunction

  function automatic int unsigned eff_height();
    if (fheight == 0) return 1;
    if (fheight > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return fheight;
  endfunction

  task automatic predict_pixel(input logic [7:0] r, g, b, input logic drain);
    int unsigned w, h, rr, cc, lin, ox, oy;
    logic [23:0] col [5];
    int d [5][5][3];
    int mean [4][3];
    int var_sum [4];
    int best, sum, sq, m, df, r0, c0;
    kpix_t res;
    w = eff_width();
    h = eff_height();
    rr = prow;
    cc = pcol;
    for (int k = 1; k <= 4; k++) begin
      col[4-k] = '0;
      if (rr >= k && rr - k < h && cc < MAX_WIDTH)
        col[4-k] = lstore[((rr - k) % LINES_KEPT) * MAX_WIDTH + cc];
    end
    col[4] = (rr < h && !drain) ? {r, g, b} : 24'h0;
    if (rr < h && cc < MAX_WIDTH) lstore[(rr % LINES_KEPT) * MAX_WIDTH + cc] = col[4];
    for (int s = 0; s < 4; s++) win[s] = win[s+1];
    for (int i = 0; i < 5; i++) win[4][i] = col[i];
    lin = rr * w + cc;
    cc++;
    if (cc >= w) begin
      cc = 0;
      rr++;
    end
    pcol = cc;
    prow = rr;
    if (lin < 2 * w + 2) return;
    ox = ocol;
    oy = orow;
    for (int s = 0; s < 5; s++)
      for (int i = 0; i < 5; i++)
        for (int ch = 0; ch < 3; ch++)
          d[i][s][ch] = (int'(ox) + s - 2 >= 0 && int'(ox) + s - 2 < int'(w)) ?
                        int'(win[s][i][16 - 8*ch +: 8]) : 0;
    for (int q = 0; q < 4; q++) begin
      r0 = (q >> 1) * 2;
      c0 = (q & 1) * 2;
      var_sum[q] = 0;
      for (int ch = 0; ch < 3; ch++) begin
        sum = 0;
        sq = 0;
        for (int a = 0; a < 3; a++)
          for (int bb = 0; bb < 3; bb++) sum += d[r0+a][c0+bb][ch];
        m = sum / 9;
        for (int a = 0; a < 3; a++)
          for (int bb = 0; bb < 3; bb++) begin
            df = d[r0+a][c0+bb][ch] - m;
            sq += df * df;
          end
        mean[q][ch] = m;
        var_sum[q] += sq / 8;
      end
    end
    best = 0;
    for (int q = 1; q < 4; q++) if (var_sum[q] < var_sum[best]) best = q;
    res.red   = 8'(mean[best][0]);
    res.green = 8'(mean[best][1]);
    res.blue  = 8'(mean[best][2]);
    res.last  = (oy == h - 1) && (ox == w - 1);
    filtered_q.push_back(res);
    if (res.last) begin
      pcol = 0; prow = 0; ocol = 0; orow = 0;
    end else begin
      ox++;
      if (ox >= w) begin
        ox = 0;
        oy++;
      end
      ocol = ox;
      orow = oy;
    end
  endtask

  // Sends one request and updates the predictor at the edge that accepts it.
  task automatic send_pixel(input logic [7:0] r, g, b, input logic drain);
    while (!no_idle && $urandom_range(0, 99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tuser  <= drain;
    do @(posedge clk); while (!in_tready);
    predict_pixel(r, g, b, drain);
    sent++;
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after its last write.
  task automatic write_reg(input cfg_reg_t idx, input logic [HREG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) fwidth = val & 13'h7FF;
    else fheight = val;
    pcol = 0; prow = 0; ocol = 0; orow = 0;
  endtask

  task automatic set_size(input logic [HREG_W-1:0] w, h);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // One full frame and its flush; junk_pct sets how many flush requests carry a pixel.
  task automatic run_frame(input int drain_pct, junk_pct, extreme);
    int unsigned w, h;
    logic [7:0] r, g, b;
    w = eff_width();
    h = eff_height();
    for (int unsigned n = 0; n < w * h; n++) begin
      if (extreme) begin
        r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end
      send_pixel(r, g, b, $urandom_range(0, 99) < drain_pct);
    end
    for (int unsigned n = 0; n < 2 * w + 2; n++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                 $urandom_range(0, 99) >= junk_pct);
    frames++;
  endtask

  task automatic test_register_extremes();
    set_size(13'd0, 13'd0);
    run_frame(0, 0, 1);
    set_size(13'd1, 13'd1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    no_idle = 1'b1;
    // Oversized width saturates; the lag is far longer than this partial frame.
    set_size(13'h1FFF, 13'd1);
    send_random(40);
    // Oversized height saturates; one column gives a result per request after a short lag.
    set_size(13'd1, 13'h1FFF);
    send_random(60);
    no_idle = 1'b0;
    set_size(13'd1024, 13'd4096);
    set_size(13'd5, 13'd2);
    run_frame(0, 50, 1);
  endtask

  task automatic test_special_cases();
    // Drain requests inside the frame and pixels past its end.
    set_size(13'd3, 13'd3);
    run_frame(40, 100, 1);
    // A register write in the middle of a frame restarts it.
    set_size(13'd4, 13'd3);
    send_random(5);
    set_size(13'd4, 13'd3);
    run_frame(10, 30, 0);
  endtask

  task automatic test_random_frames();
    int start;
    start = sent;
    while (sent - start < RANDOM_BUDGET) begin
      set_size(13'($urandom_range(1, 9)), 13'($urandom_range(1, 6)));
      no_idle = ($urandom_range(0, 5) == 0);
      run_frame($urandom_range(0, 1) ? 0 : 15, $urandom_range(0, 30), $urandom_range(0, 4) == 0);
      if (frames % 7 == 3) begin
        // Hold the sender until the filter has delivered everything outstanding.
        wait_idle();
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk) begin
    kpix_t exp_pix;
    if (rst_n && out_tvalid && out_tready) begin
      got++;
      if (filtered_q.size() == 0) begin
        $error("unexpected result tdata=%h tlast=%b", out_tdata, out_tlast);
        errors++;
      end else begin
        exp_pix = filtered_q.pop_front();
        if (out_tdata[7:0] !== exp_pix.red) begin
          $error("red_out expected %0d actual %0d", exp_pix.red, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== exp_pix.green) begin
          $error("green_out expected %0d actual %0d", exp_pix.green, out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[23:16] !== exp_pix.blue) begin
          $error("blue_out expected %0d actual %0d", exp_pix.blue, out_tdata[23:16]);
          errors++;
        end
        if (out_tlast !== exp_pix.last) begin
          $error("frame_last expected %0b actual %0b", exp_pix.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) win[i][j] = '0;
    pcol = 0; prow = 0; ocol = 0; orow = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_extremes();
    test_special_cases();
    test_random_frames();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d frames: %0d requests in, %0d filtered pixels out,", frames, sent, got);
    $display("size extremes, drains, junk flush pixels and mid-frame restarts.");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
src/kf_pkg.sv
src/kf_ram.sv
src/kf_lane.sv
src/kf_merge.sv
src/kuwahara5x5_rgb_filter_top.sv
dv/tb_kuwahara5x5_rgb_filter_top.sv
